FILE: rtl/core/lcms_pkg.sv
// ----------------------------------------------------------------------------
// lcms_pkg
// Shared widths, codes and types of the load-cell median smoother.
// ----------------------------------------------------------------------------
package lcms_pkg;

  // Window and sample geometry
  localparam int WINDOW_LEN  = 5;
  localparam int SAMPLE_BITS = 24;
  localparam int MED_K       = WINDOW_LEN / 2;          // upper middle of sorted window
  localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
  localparam int IDX_W       = $clog2(WINDOW_LEN);

  // Register and field widths
  localparam int ZO_W       = 24;
  localparam int CPN_W      = 32;
  localparam int GAIN_W     = 17;
  localparam int LIMIT_W    = 25;
  localparam int FORCE_W    = 26;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Scaling datapath
  localparam int FRAC_SHIFT = 24;                       // Q16 result, scale in 1/256
  localparam int DIFF_W     = ((SAMPLE_BITS > ZO_W) ? SAMPLE_BITS : ZO_W) + 1;
  localparam int NUM_W      = DIFF_W + FRAC_SHIFT;
  localparam int DEN_SKIP   = 8;                        // |den| >= 256: top 8 quotient bits zero
  localparam int QUO_W      = NUM_W - DEN_SKIP;
  localparam int QCNT_W     = $clog2(QUO_W);
  localparam int CAL_MIN    = 256;

  // Smoother datapath
  localparam int ERR_W   = FORCE_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + ERR_W;
  localparam int GAIN_SH = 16;
  localparam int DELTA_W = PROD_W - GAIN_SH;
  localparam int SUM_W   = DELTA_W + 1;

  localparam int FORCE_POS_LIM = (1 << (FORCE_W - 1)) - 1;
  localparam int FORCE_NEG_LIM = 1 << (FORCE_W - 1);
  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_SH);
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << GAIN_SH) - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPN         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 2'd3;

  // Register reset values
  localparam logic signed [ZO_W-1:0]  RST_ZERO_OFFSET = '0;
  localparam logic signed [CPN_W-1:0] RST_CPN         = 32'sd2155520;
  localparam logic [GAIN_W-1:0]       RST_GAIN        = 17'd22938;
  localparam logic [LIMIT_W-1:0]      RST_LIMIT       = 25'd16384000;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_CAL_BAD   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_READ_FAIL = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_DIVIDE,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } core_state_t;

  typedef enum logic [1:0] {
    MED_IDLE,
    MED_LOAD,
    MED_CMP,
    MED_CHK
  } med_state_t;

  typedef struct packed {
    logic push;   // shift a new sample into the window
    logic start;  // begin the median search
  } med_ctrl_t;

endpackage

FILE: rtl/core/lcms_median.sv
// ----------------------------------------------------------------------------
// lcms_median
// Sample window as a rotating shift line plus a rank-count median search.
// ----------------------------------------------------------------------------
module lcms_median (
  input  logic               clk,
  input  logic               rst_n,
  input  lcms_pkg::med_ctrl_t ctrl,
  input  lcms_pkg::sample_t  sample,
  output logic               done,
  output lcms_pkg::sample_t  median
);

  lcms_pkg::sample_t win_r [lcms_pkg::WINDOW_LEN];
  lcms_pkg::sample_t cand_r, cand_nxt;
  lcms_pkg::med_state_t state_r, state_nxt;
  logic [lcms_pkg::CNT_W-1:0] lt_r, lt_nxt, le_r, le_nxt;
  logic [lcms_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;
  logic rotate;
  lcms_pkg::sample_t tail;

  assign tail = rotate ? win_r[0] : sample;

  // Window shift line; rotation brings every entry past tap 0
  always_ff @(posedge clk) begin
    if (ctrl.push || rotate) begin
      for (int i = 0; i < lcms_pkg::WINDOW_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[lcms_pkg::WINDOW_LEN-1] <= tail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcms_pkg::MED_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    lt_r   <= lt_nxt;
    le_r   <= le_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    lt_nxt    = lt_r;
    le_nxt    = le_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    rotate    = 1'b0;
    unique case (state_r)
      lcms_pkg::MED_IDLE: begin
        if (ctrl.start) begin
          state_nxt = lcms_pkg::MED_LOAD;
        end
      end
      lcms_pkg::MED_LOAD: begin
        cand_nxt  = win_r[0];
        lt_nxt    = '0;
        le_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = lcms_pkg::MED_CMP;
      end
      lcms_pkg::MED_CMP: begin
        rotate  = 1'b1;
        lt_nxt  = lt_r + lcms_pkg::CNT_W'(win_r[0] < cand_r);
        le_nxt  = le_r + lcms_pkg::CNT_W'(win_r[0] <= cand_r);
        cnt_nxt = cnt_r + lcms_pkg::IDX_W'(1);
        if (cnt_r == lcms_pkg::IDX_W'(lcms_pkg::WINDOW_LEN - 1)) begin
          state_nxt = lcms_pkg::MED_CHK;
        end
      end
      lcms_pkg::MED_CHK: begin
        // candidate sits at sorted position MED_K when fewer than K+1 are below it
        // and more than K are at or below it
        if (lt_r <= lcms_pkg::CNT_W'(lcms_pkg::MED_K) &&
            le_r > lcms_pkg::CNT_W'(lcms_pkg::MED_K)) begin
          done_nxt  = 1'b1;
          state_nxt = lcms_pkg::MED_IDLE;
        end else begin
          rotate    = 1'b1;
          state_nxt = lcms_pkg::MED_LOAD;
        end
      end
      default: state_nxt = lcms_pkg::MED_IDLE;
    endcase
  end

  assign done   = done_r;
  assign median = cand_r;

endmodule

FILE: rtl/core/lcms_divider.sv
// ----------------------------------------------------------------------------
// lcms_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcms_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lcms_pkg::NUM_W-1:0]    num,
  input  logic [lcms_pkg::CPN_W-1:0]    den,
  output logic                          done,
  output logic [lcms_pkg::QUO_W-1:0]    quo
);

  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [lcms_pkg::CPN_W-1:0]  rem_r, rem_nxt;
  logic [lcms_pkg::CPN_W:0]    shifted, trial;
  logic [lcms_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [lcms_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic ge;

  // partial remainder stays below den, so the shifted value fits CPN_W bits + 1
  assign shifted = {rem_r, quo_r[lcms_pkg::QUO_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign ge      = !trial[lcms_pkg::CPN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      // top DEN_SKIP numerator bits are below den: preload them as remainder
      rem_nxt  = lcms_pkg::CPN_W'(num[lcms_pkg::NUM_W-1:lcms_pkg::QUO_W]);
      quo_nxt  = num[lcms_pkg::QUO_W-1:0];
      cnt_nxt  = lcms_pkg::QCNT_W'(lcms_pkg::QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[lcms_pkg::CPN_W-1:0] : shifted[lcms_pkg::CPN_W-1:0];
      quo_nxt = {quo_r[lcms_pkg::QUO_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - lcms_pkg::QCNT_W'(1);
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/core/load_cell_median_smoother_core.sv
// ----------------------------------------------------------------------------
// load_cell_median_smoother_core
// Median-of-five load-cell filter with scaling to newtons and IIR smoothing.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall / in_raw_count / in_read_ok): one raw
//   converter sample per item. Output channel (out_valid / out_stall /
//   out_force_value / out_status): smoothed force in signed Q10.16 newtons
//   plus a status code. cfg_we / cfg_index / cfg_data write the offset,
//   scale, gain and limit registers; write them only while the block is idle.
//   A good sample that does not complete the window yields no item and
//   leaves the block idle. A failed read or bad calibration empties the
//   window and goes to the emit step, which raises out_valid once the
//   output register is free and then returns to idle for the next item.
//   The item completing the window goes through these steps in order: the
//   median search tries candidates, each with one load, five compares over
//   the rotating window and one check, then signals done; the restoring
//   divider takes a start, then one step per quotient bit for QUO_W (41)
//   bits, then signals done; then come one multiply step, one sum step and
//   the emit step.
//   in_stall is high for the whole of that work; one item is in flight.
//   The output register decouples the sides: a new item is taken while a
//   finished result waits; the block only holds in its emit step when a
//   fresh result finds the output register still stalled.
//   Reset (rst_n low, synchronous) restores register defaults, empties the
//   window and zeroes the smoothed force; the window contents need no clear.
// ----------------------------------------------------------------------------
module load_cell_median_smoother_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [lcms_pkg::SAMPLE_BITS-1:0] in_raw_count,
  input  logic                                    in_read_ok,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [lcms_pkg::FORCE_W-1:0]     out_force_value,
  output logic [lcms_pkg::STAT_W-1:0]             out_status,
  // configuration
  input  logic                                    cfg_we,
  input  logic [lcms_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lcms_pkg::CFG_DATA_W-1:0]         cfg_data
);

  // Configuration registers
  logic signed [lcms_pkg::ZO_W-1:0]  zero_offset_r;
  logic signed [lcms_pkg::CPN_W-1:0] cpn_r;
  logic [lcms_pkg::GAIN_W-1:0]       gain_r;
  logic [lcms_pkg::LIMIT_W-1:0]      limit_r;

  // Sequencer and datapath state
  lcms_pkg::core_state_t state_r, state_nxt;
  logic [lcms_pkg::CNT_W-1:0]          fill_r, fill_nxt;
  logic signed [lcms_pkg::FORCE_W-1:0] smooth_r, smooth_nxt;
  logic                                neg_r, neg_nxt;
  logic signed [lcms_pkg::FORCE_W-1:0] f_r, f_nxt;
  logic signed [lcms_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [lcms_pkg::FORCE_W-1:0] res_force_r, res_force_nxt;
  logic [lcms_pkg::STAT_W-1:0]         res_status_r, res_status_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [lcms_pkg::FORCE_W-1:0] out_force_r, out_force_nxt;
  logic [lcms_pkg::STAT_W-1:0]         out_status_r, out_status_nxt;

  // Submodule links
  lcms_pkg::med_ctrl_t               med_ctrl;
  logic                              med_done;
  lcms_pkg::sample_t                 med_value;
  logic                              div_start, div_done;
  logic [lcms_pkg::NUM_W-1:0]        div_num;
  logic [lcms_pkg::CPN_W-1:0]        div_den;
  logic [lcms_pkg::QUO_W-1:0]        div_quo;

  // Combinational datapath
  logic                                cal_bad, out_free;
  logic signed [lcms_pkg::DIFF_W-1:0]  diff;
  logic [lcms_pkg::DIFF_W-1:0]         diff_mag;
  logic signed [lcms_pkg::FORCE_W-1:0] quo_low, f_sat;
  logic [lcms_pkg::GAIN_W-1:0]         gain_eff;
  logic signed [lcms_pkg::ERR_W-1:0]   err;
  logic [lcms_pkg::PROD_W-1:0]         prod_adj;
  logic signed [lcms_pkg::DELTA_W-1:0] delta;
  logic signed [lcms_pkg::SUM_W-1:0]   sum;
  logic signed [lcms_pkg::FORCE_W-1:0] sum_sat;
  logic [lcms_pkg::FORCE_W-1:0]        sum_mag, out_mag;

  lcms_median u_median (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (med_ctrl),
    .sample (in_raw_count),
    .done   (med_done),
    .median (med_value)
  );

  lcms_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall = (state_r != lcms_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cal_bad  = (cpn_r > -lcms_pkg::CAL_MIN) && (cpn_r < lcms_pkg::CAL_MIN);

  // Scaling: |median - offset| << 24 divided by |scale|, sign applied after
  assign diff     = lcms_pkg::DIFF_W'(med_value) - lcms_pkg::DIFF_W'(zero_offset_r);
  assign diff_mag = diff[lcms_pkg::DIFF_W-1] ? lcms_pkg::DIFF_W'(-diff)
                                             : lcms_pkg::DIFF_W'(diff);
  assign div_num  = {diff_mag, {lcms_pkg::FRAC_SHIFT{1'b0}}};
  assign div_den  = cpn_r[lcms_pkg::CPN_W-1] ? lcms_pkg::CPN_W'(-cpn_r)
                                             : lcms_pkg::CPN_W'(cpn_r);

  // Truncated quotient saturated to the force range
  assign quo_low = lcms_pkg::FORCE_W'(div_quo);
  always_comb begin
    if (neg_r) begin
      f_sat = (div_quo > lcms_pkg::QUO_W'(lcms_pkg::FORCE_NEG_LIM)) ? lcms_pkg::FORCE_MIN
                                                                    : -quo_low;
    end else begin
      f_sat = (div_quo > lcms_pkg::QUO_W'(lcms_pkg::FORCE_POS_LIM)) ? lcms_pkg::FORCE_MAX
                                                                    : quo_low;
    end
  end

  // Smoother: delta = gain * (f - s) / 2^16, truncated toward zero
  assign gain_eff = (gain_r > lcms_pkg::GAIN_ONE) ? lcms_pkg::GAIN_ONE : gain_r;
  assign err      = lcms_pkg::ERR_W'(f_r) - lcms_pkg::ERR_W'(smooth_r);
  assign prod_adj = prod_r[lcms_pkg::PROD_W-1] ? (prod_r + lcms_pkg::ROUND_BIAS)
                                               : prod_r;
  assign delta    = $signed(prod_adj[lcms_pkg::PROD_W-1:lcms_pkg::GAIN_SH]);
  assign sum      = lcms_pkg::SUM_W'(smooth_r) + lcms_pkg::SUM_W'(delta);

  always_comb begin
    if (sum > lcms_pkg::SUM_W'(lcms_pkg::FORCE_MAX)) begin
      sum_sat = lcms_pkg::FORCE_MAX;
    end else if (sum < lcms_pkg::SUM_W'(lcms_pkg::FORCE_MIN)) begin
      sum_sat = lcms_pkg::FORCE_MIN;
    end else begin
      sum_sat = lcms_pkg::FORCE_W'(sum);
    end
  end

  assign sum_mag = sum_sat[lcms_pkg::FORCE_W-1] ? lcms_pkg::FORCE_W'(-sum_sat)
                                                : lcms_pkg::FORCE_W'(sum_sat);
  assign out_mag = out_force_r[lcms_pkg::FORCE_W-1] ? lcms_pkg::FORCE_W'(-out_force_r)
                                                    : lcms_pkg::FORCE_W'(out_force_r);

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lcms_pkg::ST_IDLE;
      fill_r        <= '0;
      smooth_r      <= '0;
      out_valid_r   <= 1'b0;
      zero_offset_r <= lcms_pkg::RST_ZERO_OFFSET;
      cpn_r         <= lcms_pkg::RST_CPN;
      gain_r        <= lcms_pkg::RST_GAIN;
      limit_r       <= lcms_pkg::RST_LIMIT;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      smooth_r    <= smooth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          lcms_pkg::CFG_ZERO_OFFSET: zero_offset_r <= cfg_data[lcms_pkg::ZO_W-1:0];
          lcms_pkg::CFG_CPN:         cpn_r         <= cfg_data[lcms_pkg::CPN_W-1:0];
          lcms_pkg::CFG_GAIN:        gain_r        <= cfg_data[lcms_pkg::GAIN_W-1:0];
          lcms_pkg::CFG_LIMIT:       limit_r       <= cfg_data[lcms_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    f_r          <= f_nxt;
    prod_r       <= prod_nxt;
    res_force_r  <= res_force_nxt;
    res_status_r <= res_status_nxt;
    out_force_r  <= out_force_nxt;
    out_status_r <= out_status_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    smooth_nxt     = smooth_r;
    neg_nxt        = neg_r;
    f_nxt          = f_r;
    prod_nxt       = prod_r;
    res_force_nxt  = res_force_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_force_nxt  = out_force_r;
    out_status_nxt = out_status_r;
    med_ctrl       = '0;
    div_start      = 1'b0;
    unique case (state_r)
      lcms_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (cal_bad) begin
            // calibration checked first, even on a failed read
            fill_nxt       = '0;
            res_force_nxt  = '0;
            res_status_nxt = lcms_pkg::STAT_CAL_BAD;
            state_nxt      = lcms_pkg::ST_EMIT;
          end else if (!in_read_ok) begin
            fill_nxt       = '0;
            res_force_nxt  = '0;
            res_status_nxt = lcms_pkg::STAT_READ_FAIL;
            state_nxt      = lcms_pkg::ST_EMIT;
          end else begin
            med_ctrl.push = 1'b1;
            if (fill_r == lcms_pkg::CNT_W'(lcms_pkg::WINDOW_LEN - 1)) begin
              fill_nxt       = '0;
              med_ctrl.start = 1'b1;
              state_nxt      = lcms_pkg::ST_MEDIAN;
            end else begin
              fill_nxt = fill_r + lcms_pkg::CNT_W'(1);
            end
          end
        end
      end
      lcms_pkg::ST_MEDIAN: begin
        if (med_done) begin
          div_start = 1'b1;
          neg_nxt   = diff[lcms_pkg::DIFF_W-1] ^ cpn_r[lcms_pkg::CPN_W-1];
          state_nxt = lcms_pkg::ST_DIVIDE;
        end
      end
      lcms_pkg::ST_DIVIDE: begin
        if (div_done) begin
          f_nxt     = f_sat;
          state_nxt = lcms_pkg::ST_MUL;
        end
      end
      lcms_pkg::ST_MUL: begin
        prod_nxt  = lcms_pkg::PROD_W'($signed({1'b0, gain_eff})) * lcms_pkg::PROD_W'(err);
        state_nxt = lcms_pkg::ST_SUM;
      end
      lcms_pkg::ST_SUM: begin
        // filter is updated even when the result is out of range
        smooth_nxt     = sum_sat;
        res_force_nxt  = sum_sat;
        res_status_nxt = (sum_mag >= lcms_pkg::FORCE_W'(limit_r)) ? lcms_pkg::STAT_RANGE
                                                                  : lcms_pkg::STAT_OK;
        state_nxt      = lcms_pkg::ST_EMIT;
      end
      lcms_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_force_nxt  = res_force_r;
          out_status_nxt = res_status_r;
          state_nxt      = lcms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lcms_pkg::ST_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_force_value = out_force_r;
  assign out_status      = out_status_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < lcms_pkg::CNT_W'(lcms_pkg::WINDOW_LEN))
    else $error("window fill count out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == lcms_pkg::STAT_CAL_BAD ||
                    out_status_r == lcms_pkg::STAT_READ_FAIL)
    |-> out_force_r == '0)
    else $error("error item carries nonzero force");

  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == lcms_pkg::STAT_OK
    |-> out_mag < lcms_pkg::FORCE_W'(limit_r))
    else $error("ok status with force at or above limit");

  a_med_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    med_done |-> state_r == lcms_pkg::ST_MEDIAN)
    else $error("median done outside median step");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == lcms_pkg::ST_DIVIDE)
    else $error("divider done outside divide step");

endmodule

FILE: tb/lcms_force_checker.sv
// ----------------------------------------------------------------------------
// lcms_force_checker
// Watches the item, result and register ports of the load-cell smoother,
// predicts each result from its own copy of the state and compares them.
// ----------------------------------------------------------------------------
module lcms_force_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  lcms_pkg::sample_t                in_raw_count,
  input  logic                             in_read_ok,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [lcms_pkg::FORCE_W-1:0] out_force_value,
  input  logic [lcms_pkg::STAT_W-1:0]      out_status,
  input  logic                             cfg_we,
  input  logic [lcms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcms_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               results_due
);
  import lcms_pkg::*;

  typedef struct packed {
    logic signed [FORCE_W-1:0] newtons;
    logic [STAT_W-1:0]         status;
  } force_item_t;

  force_item_t               expected_forces[$];

  // mirrored registers
  logic signed [ZO_W-1:0]    zero_offset_r;
  logic signed [CPN_W-1:0]   scale_r;
  logic [GAIN_W-1:0]         gain_r;
  logic [LIMIT_W-1:0]        limit_r;

  // mirrored filter state
  sample_t                   window_r [WINDOW_LEN];
  int                        fill_r;
  logic signed [FORCE_W-1:0] smooth_r;
  int                        errors = 0;

  // One accepted sample in, zero or one expected force item out.
  task automatic predict_force(input sample_t raw, input logic ok);
    longint      sorted [WINDOW_LEN];
    longint      hold, diff, num, den, quo, f, gain, delta, sum, mag;
    logic        neg;
    int          j;
    force_item_t res;
    res.newtons = '0;
    if (longint'(scale_r) > -CAL_MIN && longint'(scale_r) < CAL_MIN) begin
      // bad calibration wins over everything, even a failed read
      fill_r = 0;
      res.status = STAT_CAL_BAD;
      expected_forces.push_back(res);
    end else if (!ok) begin
      fill_r = 0;
      res.status = STAT_READ_FAIL;
      expected_forces.push_back(res);
    end else begin
      window_r[fill_r] = raw;
      fill_r++;
      if (fill_r == WINDOW_LEN) begin
        fill_r = 0;
        for (int i = 0; i < WINDOW_LEN; i++) sorted[i] = longint'(window_r[i]);
        for (int i = 1; i < WINDOW_LEN; i++) begin
          hold = sorted[i];
          j = i;
          while (j > 0 && sorted[j-1] > hold) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = hold;
        end
        // sign-magnitude divide, truncates toward zero, then clamp to 26 bits
        diff = sorted[MED_K] - longint'(zero_offset_r);
        neg  = (diff < 0);
        num  = neg ? -diff : diff;
        den  = longint'(scale_r);
        if (den < 0) begin
          neg = !neg;
          den = -den;
        end
        quo = (num <<< FRAC_SHIFT) / den;
        if (neg) f = (quo > longint'(FORCE_NEG_LIM)) ? -longint'(FORCE_NEG_LIM) : -quo;
        else f = (quo > longint'(FORCE_POS_LIM)) ? longint'(FORCE_POS_LIM) : quo;
        // gains above one act as one
        gain  = (gain_r > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_r);
        delta = (gain * (f - longint'(smooth_r))) / (longint'(1) <<< GAIN_SH);
        sum   = longint'(smooth_r) + delta;
        if (sum > longint'(FORCE_POS_LIM)) sum = longint'(FORCE_POS_LIM);
        if (sum < -longint'(FORCE_NEG_LIM)) sum = -longint'(FORCE_NEG_LIM);
        smooth_r = sum[FORCE_W-1:0];
        mag = (sum < 0) ? -sum : sum;
        res.newtons = smooth_r;
        res.status  = (mag >= longint'(limit_r)) ? STAT_RANGE : STAT_OK;
        expected_forces.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    force_item_t want;
    if (!rst_n) begin
      zero_offset_r = RST_ZERO_OFFSET;
      scale_r       = RST_CPN;
      gain_r        = RST_GAIN;
      limit_r       = RST_LIMIT;
      fill_r        = 0;
      smooth_r      = '0;
      expected_forces.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZERO_OFFSET: zero_offset_r = cfg_data[ZO_W-1:0];
          CFG_CPN:         scale_r       = cfg_data[CPN_W-1:0];
          CFG_GAIN:        gain_r        = cfg_data[GAIN_W-1:0];
          CFG_LIMIT:       limit_r       = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_force(in_raw_count, in_read_ok);
      if (out_valid && !out_stall) begin
        if (expected_forces.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, got force %0d status %0d",
                   $time, out_force_value, out_status);
        end else begin
          want = expected_forces.pop_front();
          if (out_force_value !== want.newtons) begin
            errors++;
            $display("%0t: force_value mismatch, expected %0d, got %0d",
                     $time, want.newtons, out_force_value);
          end
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
          end
        end
      end
    end
    mismatches  <= errors;
    results_due <= expected_forces.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the load-cell median smoother with directed and random items under
// changing calibrations and handshake pressure; the checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
  import lcms_pkg::*;

  localparam int PERIOD      = 20;
  localparam int CYCLE_LIMIT = 1_000_000;  // far above the slowest legal run
  localparam int DRAIN_GAP   = 100;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  sample_t                      in_raw_count = '0;
  logic                         in_read_ok   = 1'b0;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic signed [FORCE_W-1:0]    out_force_value;
  logic [STAT_W-1:0]            out_status;
  logic                         cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index    = '0;
  logic [CFG_DATA_W-1:0]        cfg_data     = '0;

  int mismatches;
  int results_due;
  int send_idle_pct = 30;
  int recv_idle_pct = 50;
  int cycle_count   = 0;

  load_cell_median_smoother_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_count    (in_raw_count),
    .in_read_ok      (in_read_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_force_value (out_force_value),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  lcms_force_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_count    (in_raw_count),
    .in_read_ok      (in_read_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_force_value (out_force_value),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_due     (results_due)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Result side back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one item from a falling edge, hold it until taken, then maybe idle.
  // When no idle is drawn valid stays high into the next item.
  task automatic send_item(input int raw, input logic ok);
    in_valid     <= 1'b1;
    in_raw_count <= sample_t'(raw);
    in_read_ok   <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every predicted item has come back, then
  // give a window that produced no item time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Registers are only touched with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic set_calibration(input int offset_v, input logic [31:0] cpn_v,
                                 input int gain_v, input int limit_v);
    drain();
    write_reg(CFG_ZERO_OFFSET, offset_v);
    write_reg(CFG_CPN, cpn_v);
    write_reg(CFG_GAIN, gain_v);
    write_reg(CFG_LIMIT, limit_v);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          offset_v, gain_v, limit_v, center, raw_v, pick;
    logic [31:0] cpn_v;
    logic        ok;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part, reset calibration ---
    send_item(0, 1'b0);                  // failed read on an empty window
    send_item(1000, 1'b1);               // partial window ...
    send_item(2000, 1'b1);
    send_item(3000, 1'b0);               // ... thrown away by a failed read
    repeat (5) send_item(8388607, 1'b1); // top of range, quotient saturates high
    repeat (5) send_item(-8388608, 1'b1);// bottom of range, saturates low

    // scale of zero: every item reports bad calibration, read status ignored
    set_calibration(0, 32'd0, int'(RST_GAIN), int'(RST_LIMIT));
    send_item(100, 1'b1);
    send_item(100, 1'b0);

    // smallest legal negative scale, gain above one, zero limit
    set_calibration(-8388608, -32'sd256, 131071, 0);
    send_item(8388607, 1'b1);
    send_item(-8388608, 1'b1);
    send_item(123456, 1'b1);
    send_item(-1, 1'b1);
    send_item(0, 1'b1);

    // --- random part: one calibration per phase ---
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 50;
      end else if (phase < 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      offset_v = int'($urandom_range(4194304)) - 2097152;
      cpn_v    = $urandom_range(8000000, 256);
      if ($urandom_range(1)) cpn_v = -cpn_v;
      gain_v   = $urandom_range(65536, 1);
      limit_v  = $urandom_range(20000000, 1);
      case (phase)
        0: begin                            // reset values written back
          offset_v = int'(RST_ZERO_OFFSET);
          cpn_v    = RST_CPN;
          gain_v   = int'(RST_GAIN);
          limit_v  = int'(RST_LIMIT);
        end
        1: begin
          offset_v = -8388608;
          gain_v   = 0;                     // filter frozen at its last value
        end
        2: begin
          offset_v = 8388607;
          gain_v   = 65536;                 // filter follows input exactly
        end
        3: begin
          cpn_v   = 32'h7FFF_FFFF;
          limit_v = 0;                      // everything out of range
        end
        4: begin
          cpn_v   = 32'h8000_0000;
          limit_v = 33554431;
        end
        5: cpn_v = int'($urandom_range(510)) - 255;   // bad calibration
        6: gain_v = $urandom_range(131071, 65537);
        default: cpn_v = $urandom_range(1) ? 32'd256 : -32'sd256;
      endcase
      set_calibration(offset_v, cpn_v, gain_v, limit_v);

      center = offset_v + int'($urandom_range(4194304)) - 2097152;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == PHASE_ITEMS / 2) drain();
        if ($urandom_range(39) == 0)
          center = offset_v + int'($urandom_range(4194304)) - 2097152;
        pick = $urandom_range(99);
        if (pick < 70) begin
          raw_v = center + int'($urandom_range(4000)) - 2000;  // clustered readings
        end else if (pick < 88) begin
          raw_v = $urandom;                                    // full 24-bit noise
        end else begin
          case ($urandom_range(3))
            0:       raw_v = 8388607;
            1:       raw_v = -8388608;
            2:       raw_v = 0;
            default: raw_v = -1;
          endcase
        end
        ok = ($urandom_range(99) >= 4);
        send_item(raw_v, ok);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
